>>> design/fifo_with_remove_by_value_unit_macros.svh
// Assertion macros shared by the checker of the queue with remove by value.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef FIFO_WITH_REMOVE_BY_VALUE_UNIT_MACROS_SVH
`define FIFO_WITH_REMOVE_BY_VALUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define FWR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/fwr_pkg.sv
// Package for the queue with remove by value: default sizes, opcodes,
// sequencer states and the status flags handed to the output stage. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fwr_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OPCODE_W        = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } fwr_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_SEARCH,
    ST_SHIFT,
    ST_FRONT_RD,
    ST_FRONT_WAIT
  } fwr_state_t;

  typedef struct packed {
    logic pop_valid;
    logic remove_found;
    logic push_dropped;
    logic front_valid;
  } fwr_flags_t;

endpackage

`default_nettype wire

>>> design/fwr_if.sv
// Valid/ready channel interfaces for the request and response words of the queue.
// Depends on nothing; widths come from the instantiating level.
`timescale 1ns / 1ps
`default_nettype none

interface fwr_req_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface fwr_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 5
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] popped_value;
  logic                   pop_valid;
  logic                   remove_found;
  logic                   push_dropped;
  logic [VALUE_WIDTH-1:0] front_value;
  logic                   front_valid;
  logic [CNT_W-1:0]       occupancy;

  modport source (
    output valid, output popped_value, output pop_valid, output remove_found,
    output push_dropped, output front_value, output front_valid, output occupancy,
    input ready
  );
  modport sink (
    input valid, input popped_value, input pop_valid, input remove_found,
    input push_dropped, input front_value, input front_valid, input occupancy,
    output ready
  );
endinterface

`default_nettype wire

>>> design/fwr_out_stage.sv
// Output register of the queue: holds one response word until the sink takes it.
// Depends on fwr_pkg and fwr_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module fwr_out_stage #(
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [VALUE_WIDTH-1:0] popped,
  input  wire logic [VALUE_WIDTH-1:0] front,
  input  wire logic [CNT_W-1:0]       count,
  input  wire fwr_pkg::fwr_flags_t    flags,
  output logic                        free,
  fwr_rsp_if.source                   rsp
);
  import fwr_pkg::*;

  logic                   valid;
  logic [VALUE_WIDTH-1:0] popped_r;
  logic [VALUE_WIDTH-1:0] front_r;
  logic [CNT_W-1:0]       count_r;
  fwr_flags_t             flags_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      popped_r <= popped;
      front_r  <= front;
      count_r  <= count;
      flags_r  <= flags;
    end
  end

  assign free              = !valid || rsp.ready;
  assign rsp.valid         = valid;
  assign rsp.popped_value  = popped_r;
  assign rsp.pop_valid     = flags_r.pop_valid;
  assign rsp.remove_found  = flags_r.remove_found;
  assign rsp.push_dropped  = flags_r.push_dropped;
  assign rsp.front_value   = front_r;
  assign rsp.front_valid   = flags_r.front_valid;
  assign rsp.occupancy     = count_r;

endmodule

`default_nettype wire

>>> design/fifo_with_remove_by_value_unit.sv
// Bounded queue with push, pop and remove of the newest matching value; any other opcode
// only reports the front entry and the count. A remove searches from the newest entry
// towards the head and, after a hit, moves every newer entry one place towards the head.
// One request is in work at a time; the simple dual-port memory (one read, one write a
// cycle) sets the rate. Reset clears the count and head pointer; the entry memory is not
// cleared. A finished response word waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_remove_by_value_unit #(
  parameter int DEPTH       = fwr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = fwr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  fwr_req_if.sink   req,
  fwr_rsp_if.source rsp
);
  import fwr_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fwr_state_t state;
  fwr_state_t state_next;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;

  logic [AW-1:0]          head;
  logic [CNT_W-1:0]       count;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [VALUE_WIDTH-1:0] popped;
  logic                   pop_ok;
  logic                   found;
  logic                   dropped;

  logic [CNT_W-1:0]       srch_idx;
  logic [CNT_W-1:0]       srch_pend_idx;
  logic                   srch_pend;
  logic [CNT_W-1:0]       sh_k;
  logic [CNT_W-1:0]       sh_dst;
  logic                   sh_pend;

  logic                   match;
  logic                   out_free;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] front_value;
  fwr_flags_t             flags;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CNT_W-1:0] l);
    logic [AW:0] s;
    s = (AW+1)'(hd) + (AW+1)'(l);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign match    = srch_pend && (rdata == value_r);
  assign req.ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.opcode)
            OP_PUSH:   state_next = ST_PUSH;
            OP_POP:    state_next = ST_POP_RD;
            OP_REMOVE: state_next = ST_SEARCH;
            default:   state_next = ST_FRONT_RD;
          endcase
        end
      end
      ST_PUSH:     state_next = ST_FRONT_RD;
      ST_POP_RD:   state_next = (count != '0) ? ST_POP_WAIT : ST_FRONT_RD;
      ST_POP_WAIT: state_next = ST_FRONT_RD;
      ST_SEARCH: begin
        if (match) begin
          state_next = ST_SHIFT;
        end else if (srch_idx == '0) begin
          state_next = ST_FRONT_RD;
        end
      end
      ST_SHIFT: begin
        if (sh_k == count && !sh_pend) begin
          state_next = ST_FRONT_RD;
        end
      end
      ST_FRONT_RD: begin
        if (out_free) begin
          state_next = ST_FRONT_WAIT;
        end
      end
      ST_FRONT_WAIT: state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    re       = 1'b0;
    raddr    = head;
    we       = 1'b0;
    waddr    = phys(head, count);
    wdata    = value_r;
    out_load = 1'b0;
    case (state)
      ST_PUSH: begin
        we = (count != CNT_W'(DEPTH));
      end
      ST_POP_RD: begin
        re = (count != '0);
      end
      ST_SEARCH: begin
        re    = !match && (srch_idx != '0);
        raddr = phys(head, srch_idx - CNT_W'(1));
      end
      ST_SHIFT: begin
        re    = (sh_k != count);
        raddr = phys(head, sh_k);
        we    = sh_pend;
        waddr = phys(head, sh_dst);
        wdata = rdata;
      end
      ST_FRONT_RD: begin
        re = out_free;
      end
      ST_FRONT_WAIT: begin
        out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_PUSH: begin
          if (count != CNT_W'(DEPTH)) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_POP_WAIT: begin
          head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
          count <= count - CNT_W'(1);
        end
        ST_SHIFT: begin
          if (sh_k == count && !sh_pend) begin
            count <= count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        value_r   <= req.value;
        popped    <= '0;
        pop_ok    <= 1'b0;
        found     <= 1'b0;
        dropped   <= 1'b0;
        srch_idx  <= count;
        srch_pend <= 1'b0;
      end
      ST_PUSH: begin
        dropped <= (count == CNT_W'(DEPTH));
      end
      ST_POP_WAIT: begin
        popped <= rdata;
        pop_ok <= 1'b1;
      end
      ST_SEARCH: begin
        if (match) begin
          found   <= 1'b1;
          sh_k    <= srch_pend_idx + CNT_W'(1);
          sh_pend <= 1'b0;
        end else if (srch_idx != '0) begin
          srch_pend     <= 1'b1;
          srch_pend_idx <= srch_idx - CNT_W'(1);
          srch_idx      <= srch_idx - CNT_W'(1);
        end
      end
      ST_SHIFT: begin
        if (sh_k != count) begin
          sh_pend <= 1'b1;
          sh_dst  <= sh_k - CNT_W'(1);
          sh_k    <= sh_k + CNT_W'(1);
        end else begin
          sh_pend <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign front_value        = (count != '0) ? rdata : '0;
  assign flags.pop_valid    = pop_ok;
  assign flags.remove_found = found;
  assign flags.push_dropped = dropped;
  assign flags.front_valid  = (count != '0);

  fwr_out_stage #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .popped (popped),
    .front  (front_value),
    .count  (count),
    .flags  (flags),
    .free   (out_free),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

>>> design/fwr_checker.sv
// Port-level checker for the queue with remove by value, bound to the top level.
// Depends on fifo_with_remove_by_value_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_with_remove_by_value_unit_macros.svh"

module fwr_checker #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [VALUE_WIDTH-1:0]        rsp_popped_value,
  input wire logic                          rsp_push_dropped,
  input wire logic [VALUE_WIDTH-1:0]        rsp_front_value,
  input wire logic                          rsp_front_valid,
  input wire logic [$clog2(DEPTH+1)-1:0]    rsp_occupancy
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  `FWR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_popped_value) && $stable(rsp_occupancy), "Response word changed while stalled.")
  `FWR_ASSERT_IMP(a_occ_bound, rsp_valid, rsp_occupancy <= CNT_W'(DEPTH), "Occupancy exceeds the depth.")
  `FWR_ASSERT_IMP(a_front_consistent, rsp_valid, (rsp_front_valid == (rsp_occupancy != '0)) && (rsp_front_valid || rsp_front_value == '0), "Front status disagrees with occupancy.")
  `FWR_ASSERT_IMP(a_drop_when_full, rsp_valid && rsp_push_dropped, rsp_occupancy == CNT_W'(DEPTH), "Push dropped while the queue was not full.")
  `FWR_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "Request taken while another is in work.")

endmodule

bind fifo_with_remove_by_value_unit fwr_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_fwr_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_popped_value (rsp.popped_value),
  .rsp_push_dropped (rsp.push_dropped),
  .rsp_front_value  (rsp.front_value),
  .rsp_front_valid  (rsp.front_valid),
  .rsp_occupancy    (rsp.occupancy)
);

`default_nettype wire

>>> test/fwr_queue_checker.sv
// Checker for the queue with remove by value: watches the request and response channels,
// keeps its own copy of the queue contents and compares every response word in order.
// Depends on fwr_pkg and the channel interfaces in fwr_if.sv.
`timescale 1ns / 1ps

module fwr_queue_checker #(
  parameter int DEPTH       = fwr_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = fwr_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  fwr_req_if   req,
  fwr_rsp_if   rsp,
  output int   mismatches,
  output int   waiting,
  output int   checked,
  output int   removes_hit,
  output int   pushes_dropped
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] popped_value;
    logic                   pop_valid;
    logic                   remove_found;
    logic                   push_dropped;
    logic [VALUE_WIDTH-1:0] front_value;
    logic                   front_valid;
    logic [CNT_W-1:0]       occupancy;
  } status_word_t;

  logic [VALUE_WIDTH-1:0] held_values[$];
  status_word_t           expected_words[$];
  int                     err_count  = 0;
  int                     word_count = 0;
  int                     hit_count  = 0;
  int                     drop_count = 0;

  function automatic status_word_t apply_request(input logic [1:0] op,
                                                 input logic [VALUE_WIDTH-1:0] v);
    status_word_t w;
    w = '0;
    case (op)
      fwr_pkg::OP_PUSH: begin
        if (held_values.size() >= DEPTH) w.push_dropped = 1'b1;
        else held_values.push_back(v);
      end
      fwr_pkg::OP_POP: begin
        if (held_values.size() > 0) begin
          w.popped_value = held_values.pop_front();
          w.pop_valid    = 1'b1;
        end
      end
      fwr_pkg::OP_REMOVE: begin
        // The newest matching entry goes, so the search runs from the tail.
        for (int i = held_values.size() - 1; i >= 0; i--) begin
          if (held_values[i] == v) begin
            held_values.delete(i);
            w.remove_found = 1'b1;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    w.front_valid = held_values.size() > 0;
    if (w.front_valid) w.front_value = held_values[0];
    w.occupancy = CNT_W'(held_values.size());
    return w;
  endfunction

  always @(posedge clk) begin
    status_word_t got;
    status_word_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.popped_value = rsp.popped_value;
        got.pop_valid    = rsp.pop_valid;
        got.remove_found = rsp.remove_found;
        got.push_dropped = rsp.push_dropped;
        got.front_value  = rsp.front_value;
        got.front_valid  = rsp.front_valid;
        got.occupancy    = rsp.occupancy;
        word_count++;
        if (expected_words.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("Response word %0d arrived with no request waiting for it.", word_count);
          end
        end else begin
          want = expected_words.pop_front();
          if (want.remove_found) hit_count++;
          if (want.push_dropped) drop_count++;
          if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("Response word %0d differs (pop value/valid, found, dropped, front/valid, count):",
                       word_count);
              $display("  expected %h/%b %b %b %h/%b %0d", want.popped_value, want.pop_valid,
                       want.remove_found, want.push_dropped, want.front_value,
                       want.front_valid, want.occupancy);
              $display("  actual   %h/%b %b %b %h/%b %0d", got.popped_value, got.pop_valid,
                       got.remove_found, got.push_dropped, got.front_value,
                       got.front_valid, got.occupancy);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_words.push_back(apply_request(req.opcode, req.value));
      end
    end
    mismatches     <= err_count;
    waiting        <= expected_words.size();
    checked        <= word_count;
    removes_hit    <= hit_count;
    pushes_dropped <= drop_count;
  end

endmodule

>>> test/tb_fifo_with_remove_by_value_unit.sv
// Top of the testbench for the queue with remove by value: clock, reset, request stimulus,
// response stalls and the verdict. Depends on fwr_pkg, fwr_if.sv, the unit and fwr_queue_checker.
`timescale 1ns / 1ps

module tb_fifo_with_remove_by_value_unit;

  localparam int          DEPTH       = fwr_pkg::DEPTH_DEF;
  localparam int          VALUE_WIDTH = fwr_pkg::VALUE_WIDTH_DEF;
  localparam int          CNT_W       = $clog2(DEPTH + 1);
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          TAIL_CYCLES = 2 * DEPTH + 25;
  localparam int          PHASE_WORDS = 220;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic clk;
  logic rst;
  int   sender_idle    = 0;
  int   receiver_stall = 0;
  int   cycle_count    = 0;
  int   words_sent     = 0;
  int   push_pct       = 50;
  logic [VALUE_WIDTH-1:0] pool[8];

  int mismatches;
  int waiting;
  int checked;
  int removes_hit;
  int pushes_dropped;

  fwr_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
  fwr_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .CNT_W(CNT_W)) rsp_ch ();

  fifo_with_remove_by_value_unit #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fwr_queue_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatches     (mismatches),
    .waiting        (waiting),
    .checked        (checked),
    .removes_hit    (removes_hit),
    .pushes_dropped (pushes_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d words outstanding.", cycle_count, waiting);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [VALUE_WIDTH-1:0] v);
    while ($urandom_range(99) < sender_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.value  <= v;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
  endtask

  task automatic drain_queue();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    if ($urandom_range(99) < 65) return pool[$urandom_range(7)];
    return VALUE_WIDTH'($urandom());
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int         made;
    int         roll;
    logic [1:0] op;
    made = 0;
    sender_idle    <= idle_pct;
    receiver_stall <= stall_pct;
    while (made < PHASE_WORDS) begin
      if (made % 24 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 50;
          default: push_pct = 25;
        endcase
        pool[$urandom_range(7, 2)] = VALUE_WIDTH'($urandom());
      end
      roll = $urandom_range(99);
      if ($urandom_range(99) < 3) begin
        op = OP_UNUSED;
      end else begin
        made++;
        if (roll < push_pct) op = fwr_pkg::OP_PUSH;
        else if (roll < push_pct + (100 - push_pct) / 2) op = fwr_pkg::OP_POP;
        else op = fwr_pkg::OP_REMOVE;
      end
      send_word(op, pick_value());
    end
    drain_queue();
  endtask

  initial begin
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= fwr_pkg::OP_PUSH;
    req_ch.value  <= '0;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 8; i++) pool[i] = VALUE_WIDTH'($urandom());
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(fwr_pkg::OP_POP, '0);
    send_word(fwr_pkg::OP_REMOVE, '0);
    send_word(OP_UNUSED, '1);
    send_word(fwr_pkg::OP_PUSH, '1);
    send_word(fwr_pkg::OP_PUSH, '0);
    send_word(fwr_pkg::OP_PUSH, 32'hA5A5_A5A5);
    send_word(fwr_pkg::OP_PUSH, '0);
    send_word(fwr_pkg::OP_PUSH, 32'h5A5A_5A5A);
    for (int i = 0; i < DEPTH - 5; i++) send_word(fwr_pkg::OP_PUSH, VALUE_WIDTH'(i + 1));
    send_word(fwr_pkg::OP_PUSH, 32'hDEAD_0001);
    send_word(fwr_pkg::OP_REMOVE, '0);
    send_word(fwr_pkg::OP_REMOVE, 32'h1234_5678);
    send_word(OP_UNUSED, '0);
    send_word(fwr_pkg::OP_POP, '0);
    send_word(fwr_pkg::OP_REMOVE, 32'h5A5A_5A5A);
    drain_queue();

    run_phase(0, 0);
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(30, 30);
    run_phase(0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d request words through directed cases and five idle/stall phases.",
             words_sent);
    $display("Checked %0d response words; %0d removes hit a match, %0d pushes met a full queue.",
             checked, removes_hit, pushes_dropped);
    if (mismatches == 0 && waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/fwr_pkg.sv
design/fwr_if.sv
design/fwr_out_stage.sv
design/fifo_with_remove_by_value_unit.sv
design/fwr_checker.sv
test/fwr_queue_checker.sv
test/tb_fifo_with_remove_by_value_unit.sv
